[rtl/core/sdq_pkg.sv]
`timescale 1ns / 1ps

package sdq_pkg;

    localparam int ID_W            = 8;
    localparam int DELTA_W         = 31;
    localparam int ENTRY_W         = ID_W + DELTA_W;
    localparam int DEFAULT_ENTRIES = 32;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POLL   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN,
        ST_DONE
    } sdq_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic walk;
        logic fin;
        logic load;
    } sdq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic quick;
        logic walk_done;
        logic out_busy;
    } sdq_stat_t;

endpackage

[rtl/core/sdq_ram.sv]
`timescale 1ns / 1ps

module sdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/sdq_ctrl.sv]
`timescale 1ns / 1ps

module sdq_ctrl import sdq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sdq_stat_t stat,
    output sdq_cmd_t  cmd
);

    sdq_state_t state_reg;
    sdq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.quick ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        cmd.start = (state_reg == ST_IDLE) && in_valid;
        cmd.walk  = (state_reg == ST_WALK);
        cmd.fin   = (state_reg == ST_FIN);
        cmd.load  = (state_reg == ST_DONE) && !stat.out_busy;
    end

endmodule

[rtl/core/sdq_dp.sv]
`timescale 1ns / 1ps

module sdq_dp import sdq_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sdq_cmd_t                     cmd,
    output sdq_stat_t                    stat,
    input  logic [1:0]                   opcode,
    input  logic [ID_W-1:0]              proc_id,
    input  logic [DELTA_W-1:0]           delay,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [1:0]                   status,
    output logic [ID_W-1:0]              out_id,
    output logic [DELTA_W-1:0]           out_time,
    output logic                         head_valid,
    output logic [ID_W-1:0]              head_id,
    output logic [DELTA_W-1:0]           head_delta,
    output logic [$clog2(ENTRIES+1)-1:0] entry_count
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             dv_reg, dv_next;
    logic             hit_reg, hit_next;
    logic             out_valid_reg, out_valid_next;

    // working payload
    logic [1:0]         op_reg, op_next;
    logic [ID_W-1:0]    pid_reg, pid_next;
    logic [DELTA_W-1:0] rem_reg, rem_next;
    logic [DELTA_W-1:0] acc_reg, acc_next;
    logic [DELTA_W-1:0] fd_reg, fd_next;
    logic [ENTRY_W-1:0] carry_reg, carry_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [1:0]         sts_reg, sts_next;
    logic [ID_W-1:0]    oid_reg, oid_next;
    logic [DELTA_W-1:0] otime_reg, otime_next;
    logic [ID_W-1:0]    hid_reg, hid_next;
    logic [DELTA_W-1:0] hdelta_reg, hdelta_next;

    // result beat
    logic [1:0]         o_sts_reg, o_sts_next;
    logic [ID_W-1:0]    o_id_reg, o_id_next;
    logic [DELTA_W-1:0] o_time_reg, o_time_next;
    logic               o_hv_reg, o_hv_next;
    logic [ID_W-1:0]    o_hid_reg, o_hid_next;
    logic [DELTA_W-1:0] o_hdelta_reg, o_hdelta_next;
    logic [CNT_W-1:0]   o_cnt_reg, o_cnt_next;

    // entry store
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [ID_W-1:0]    rd_id;
    logic [DELTA_W-1:0] rd_delta;
    logic [DELTA_W-1:0] acc_sum;
    logic               match;

    sdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    assign rd_id    = rdata[ENTRY_W-1:DELTA_W];
    assign rd_delta = rdata[DELTA_W-1:0];
    assign acc_sum  = acc_reg + rd_delta;
    assign match    = (op_reg == OP_POLL) ? (pos_reg == '0) : (rd_id == pid_reg);

    always_comb
    begin
        stat.out_busy  = out_valid_reg && !out_ready;
        stat.walk_done = (rd_idx_reg == count_reg) && !dv_reg;
        if (opcode == OP_INSERT)
        begin
            stat.quick = (count_reg == FULL_CNT);
        end
        else if (opcode == OP_POLL || opcode == OP_REMOVE)
        begin
            stat.quick = (count_reg == '0);
        end
        else
        begin
            stat.quick = 1'b1;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        dv_next        = 1'b0;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        pid_next       = pid_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        fd_next        = fd_reg;
        carry_next     = carry_reg;
        pos_next       = pos_reg;
        sts_next       = sts_reg;
        oid_next       = oid_reg;
        otime_next     = otime_reg;
        hid_next       = hid_reg;
        hdelta_next    = hdelta_reg;
        o_sts_next     = o_sts_reg;
        o_id_next      = o_id_reg;
        o_time_next    = o_time_reg;
        o_hv_next      = o_hv_reg;
        o_hid_next     = o_hid_reg;
        o_hdelta_next  = o_hdelta_reg;
        o_cnt_next     = o_cnt_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;

        if (cmd.start)
        begin
            op_next     = opcode;
            pid_next    = proc_id;
            rem_next    = delay;
            acc_next    = '0;
            fd_next     = '0;
            hit_next    = 1'b0;
            rd_idx_next = '0;
            oid_next    = '0;
            otime_next  = '0;
            sts_next    = STS_OK;
            if (opcode == OP_INSERT && count_reg == FULL_CNT)
            begin
                sts_next = STS_FULL;
            end
            else if ((opcode == OP_POLL || opcode == OP_REMOVE) && count_reg == '0)
            begin
                sts_next = STS_EMPTY;
            end
        end

        if (cmd.walk)
        begin
            // issue the next read one slot ahead of the entry being processed
            if (rd_idx_reg < count_reg)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                dv_next     = 1'b1;
                pos_next    = rd_idx_reg[IDX_W-1:0];
            end
            if (dv_reg)
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (!hit_reg)
                    begin
                        if (rem_reg < rd_delta)
                        begin
                            // place here, push the old entry down with a reduced delta
                            we         = 1'b1;
                            waddr      = pos_reg;
                            wdata      = {pid_reg, rem_reg};
                            carry_next = {rd_id, rd_delta - rem_reg};
                            hit_next   = 1'b1;
                        end
                        else
                        begin
                            rem_next = rem_reg - rd_delta;
                        end
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = pos_reg;
                        wdata      = carry_reg;
                        carry_next = rdata;
                    end
                end
                else
                begin
                    if (!hit_reg)
                    begin
                        if (match)
                        begin
                            hit_next   = 1'b1;
                            otime_next = acc_sum;
                            oid_next   = rd_id;
                            fd_next    = rd_delta;
                        end
                        else
                        begin
                            acc_next = acc_sum;
                        end
                    end
                    else
                    begin
                        // pull up one slot; the successor absorbs the dropped delta
                        we      = 1'b1;
                        waddr   = pos_reg - IDX_W'(1);
                        wdata   = {rd_id, rd_delta + fd_reg};
                        fd_next = '0;
                    end
                end
            end
        end

        if (cmd.fin)
        begin
            if (op_reg == OP_INSERT)
            begin
                we         = 1'b1;
                waddr      = count_reg[IDX_W-1:0];
                wdata      = hit_reg ? carry_reg : {pid_reg, rem_reg};
                count_next = count_reg + CNT_W'(1);
            end
            else if (hit_reg)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            else
            begin
                sts_next = STS_NOT_FOUND;
            end
        end

        // mirror slot zero for the head report
        if (we && waddr == '0)
        begin
            hid_next    = wdata[ENTRY_W-1:DELTA_W];
            hdelta_next = wdata[DELTA_W-1:0];
        end

        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            o_sts_next     = sts_reg;
            o_id_next      = oid_reg;
            o_time_next    = otime_reg;
            o_hv_next      = (count_reg != '0);
            o_hid_next     = (count_reg != '0) ? hid_reg : '0;
            o_hdelta_next  = (count_reg != '0) ? hdelta_reg : '0;
            o_cnt_next     = count_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            dv_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            dv_reg        <= dv_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pid_reg      <= pid_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        fd_reg       <= fd_next;
        carry_reg    <= carry_next;
        pos_reg      <= pos_next;
        sts_reg      <= sts_next;
        oid_reg      <= oid_next;
        otime_reg    <= otime_next;
        hid_reg      <= hid_next;
        hdelta_reg   <= hdelta_next;
        o_sts_reg    <= o_sts_next;
        o_id_reg     <= o_id_next;
        o_time_reg   <= o_time_next;
        o_hv_reg     <= o_hv_next;
        o_hid_reg    <= o_hid_next;
        o_hdelta_reg <= o_hdelta_next;
        o_cnt_reg    <= o_cnt_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = o_sts_reg;
    assign out_id      = o_id_reg;
    assign out_time    = o_time_reg;
    assign head_valid  = o_hv_reg;
    assign head_id     = o_hid_reg;
    assign head_delta  = o_hdelta_reg;
    assign entry_count = o_cnt_reg;

endmodule

[rtl/core/sleep_delta_queue.sv]
`timescale 1ns / 1ps

// Channel   Handshake             Beat contents
// -------   -------------------   ---------------------------------------------------
// in        in_valid / in_ready   opcode, proc_id, delay
// out       out_valid / out_ready status, out_id, out_time, head_valid, head_id,
//                                 head_delta, entry_count
//
// Insert, poll and remove walk the stored entries once through the entry RAM, one
// entry per cycle with each registered read issued one slot ahead, then pass
// through the FIN state to DONE, where the result is loaded into the output
// register once it is free; the next beat is taken back in IDLE. Full, empty
// and no-op items skip the walk and go from accept straight to DONE.
// Reset: asynchronous, active low; clears the entry count and the handshake state.
// The entry RAM is not cleared; only slots below the count are ever read.
// Stalls: a finished result holds in the output register until out_ready; the
// next beat is still accepted and walked, then holds in its last state, with
// in_ready low, until that result is handed over.

module sleep_delta_queue import sdq_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic [ID_W-1:0]              proc_id,
    input  logic [DELTA_W-1:0]           delay,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [ID_W-1:0]              out_id,
    output logic [DELTA_W-1:0]           out_time,
    output logic                         head_valid,
    output logic [ID_W-1:0]              head_id,
    output logic [DELTA_W-1:0]           head_delta,
    output logic [$clog2(ENTRIES+1)-1:0] entry_count
);

    sdq_cmd_t  cmd;
    sdq_stat_t stat;

    // sequence the walk: accept, stream entries, finish, hand over the beat
    sdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // entry store, list arithmetic and the output register
    sdq_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .proc_id     (proc_id),
        .delay       (delay),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .status      (status),
        .out_id      (out_id),
        .out_time    (out_time),
        .head_valid  (head_valid),
        .head_id     (head_id),
        .head_delta  (head_delta),
        .entry_count (entry_count)
    );

endmodule

[verif/sleep_delta_queue_tb.sv]
`timescale 1ns / 1ps

module sleep_delta_queue_tb import sdq_pkg::*; ();

    localparam int ENTRIES     = DEFAULT_ENTRIES;
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int STALL_LIMIT = 4000;   // cycles with no beat on either channel
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int MAX_REPORTS = 40;

    localparam logic [1:0]         OP_NOP    = 2'd3;   // not decoded by the block
    localparam logic [DELTA_W-1:0] DELAY_MAX = '1;

    // One output beat, field by field
    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    out_id;
        logic [DELTA_W-1:0] out_time;
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [DELTA_W-1:0] head_delta;
        logic [CNT_W-1:0]   entry_count;
    } sleep_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           opcode = '0;
    logic [ID_W-1:0]      proc_id = '0;
    logic [DELTA_W-1:0]   delay = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           status;
    logic [ID_W-1:0]      out_id;
    logic [DELTA_W-1:0]   out_time;
    logic                 head_valid;
    logic [ID_W-1:0]      head_id;
    logic [DELTA_W-1:0]   head_delta;
    logic [CNT_W-1:0]     entry_count;

    // Shadow copy of the sleep list, head at slot 0, deltas relative to the slot ahead
    logic [ID_W-1:0]      sleeper_ids    [ENTRIES];
    logic [DELTA_W-1:0]   sleeper_deltas [ENTRIES];
    int                   sleeper_count = 0;

    // Results owed by the block, oldest first
    sleep_result_t        results_due[$];

    int                   mismatch_count = 0;
    int                   tx_idle_pct = 0;    // chance per cycle that the sender idles
    int                   rx_stall_pct = 0;   // chance per cycle that the receiver stalls
    int                   rx_hold_left = 0;   // remaining cycles of a forced hold-off
    int                   quiet_cycles = 0;

    sleep_delta_queue #(.ENTRIES(ENTRIES)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .proc_id     (proc_id),
        .delay       (delay),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_id      (out_id),
        .out_time    (out_time),
        .head_valid  (head_valid),
        .head_id     (head_id),
        .head_delta  (head_delta),
        .entry_count (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sleep list predictor
    // ------------------------------------------------------------------

    // Close the gap at slot pos by moving every later entry up by one
    function automatic void drop_sleeper(input int pos);
        int idx;
        for (idx = pos; idx + 1 < sleeper_count; idx++)
        begin
            sleeper_ids[idx]    = sleeper_ids[idx + 1];
            sleeper_deltas[idx] = sleeper_deltas[idx + 1];
        end
        sleeper_count--;
    endfunction

    // Apply one operation to the shadow list and return the beat it must produce
    function automatic sleep_result_t sleep_list_apply(input logic [1:0] op,
                                                       input logic [ID_W-1:0] pid,
                                                       input logic [DELTA_W-1:0] dly);
        sleep_result_t      res;
        int                 pos;
        int                 idx;
        int                 found;
        logic [DELTA_W-1:0] rem;
        logic [63:0]        acc;
        res = '0;
        case (op)
            OP_INSERT:
            begin
                if (sleeper_count >= ENTRIES)
                begin
                    res.status = STS_FULL;
                end
                else
                begin
                    // walk past every entry that wakes no later than the new one
                    pos = sleeper_count;
                    rem = dly;
                    for (idx = 0; idx < sleeper_count; idx++)
                    begin
                        if (rem < sleeper_deltas[idx])
                        begin
                            pos = idx;
                            break;
                        end
                        rem = rem - sleeper_deltas[idx];
                    end
                    // the follower now counts from the new entry
                    if (pos < sleeper_count)
                        sleeper_deltas[pos] = sleeper_deltas[pos] - rem;
                    for (idx = sleeper_count; idx > pos; idx--)
                    begin
                        sleeper_ids[idx]    = sleeper_ids[idx - 1];
                        sleeper_deltas[idx] = sleeper_deltas[idx - 1];
                    end
                    sleeper_ids[pos]    = pid;
                    sleeper_deltas[pos] = rem;
                    sleeper_count++;
                end
            end
            OP_POLL:
            begin
                if (sleeper_count == 0)
                begin
                    res.status = STS_EMPTY;
                end
                else
                begin
                    res.out_id   = sleeper_ids[0];
                    res.out_time = sleeper_deltas[0];
                    // no successor to update when the last entry goes
                    if (sleeper_count > 1)
                        sleeper_deltas[1] = sleeper_deltas[1] + sleeper_deltas[0];
                    drop_sleeper(0);
                end
            end
            OP_REMOVE:
            begin
                if (sleeper_count == 0)
                begin
                    res.status = STS_EMPTY;
                end
                else
                begin
                    // first match from the head wins, summing the wake time on the way
                    acc   = '0;
                    found = -1;
                    for (idx = 0; idx < sleeper_count; idx++)
                    begin
                        acc = acc + 64'(sleeper_deltas[idx]);
                        if (sleeper_ids[idx] == pid)
                        begin
                            found = idx;
                            break;
                        end
                    end
                    if (found < 0)
                    begin
                        res.status = STS_NOT_FOUND;
                    end
                    else
                    begin
                        res.out_id   = pid;
                        res.out_time = acc[DELTA_W-1:0];
                        if (found + 1 < sleeper_count)
                            sleeper_deltas[found + 1] = sleeper_deltas[found + 1]
                                                        + sleeper_deltas[found];
                        drop_sleeper(found);
                    end
                end
            end
            default:
            begin
                // no operation: only the head and count are reported
            end
        endcase
        if (sleeper_count > 0)
        begin
            res.head_valid = 1'b1;
            res.head_id    = sleeper_ids[0];
            res.head_delta = sleeper_deltas[0];
        end
        res.entry_count = sleeper_count[CNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Often small delays so that wake times collide, with some wide and extreme ones
    function automatic logic [DELTA_W-1:0] pick_delay();
        logic [DELTA_W-1:0] dly;
        case ($urandom_range(9))
            0, 1, 2, 3: dly = DELTA_W'($urandom_range(15));
            4, 5:       dly = DELTA_W'($urandom_range(1000));
            6:          dly = DELAY_MAX - DELTA_W'($urandom_range(3));
            default:    dly = DELTA_W'($urandom());
        endcase
        return dly;
    endfunction

    // A small pool of ids makes duplicates common
    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] pid;
        if ($urandom_range(1) == 0)
            pid = ID_W'($urandom_range(7));
        else
            pid = ID_W'($urandom_range(255));
        return pid;
    endfunction

    function automatic int sender_gap();
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct)
            gap++;
        return gap;
    endfunction

    // Offer one beat and hold it until accepted. Enter and leave on a falling edge;
    // valid stays high on return so a back-to-back beat needs no extra assignment.
    task automatic send_beat(input logic [1:0] op, input logic [ID_W-1:0] pid,
                             input logic [DELTA_W-1:0] dly);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        proc_id  <= pid;
        delay    <= dly;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        results_due.push_back(sleep_list_apply(op, pid, dly));
        @(negedge clk);
    endtask

    // Drop valid and wait until the block has handed over every owed beat;
    // always move on by at least one falling edge
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Poll, remove and no-op against an empty list, with the input fields at their extremes
    task automatic test_empty_list();
        send_beat(OP_POLL, 8'hFF, DELAY_MAX);
        send_beat(OP_REMOVE, 8'h00, '0);
        send_beat(OP_REMOVE, 8'hFF, DELAY_MAX);
        send_beat(OP_NOP, 8'hFF, DELAY_MAX);
    endtask

    // Ordering rules: ties go behind, duplicates, head and tail removal, last poll
    task automatic test_ordering();
        send_beat(OP_INSERT, 8'h00, '0);
        send_beat(OP_INSERT, 8'h81, '0);           // tie at zero goes behind
        send_beat(OP_INSERT, 8'hFF, DELAY_MAX);    // widest delay lands at the tail
        send_beat(OP_INSERT, 8'h5A, 31'd100);
        send_beat(OP_INSERT, 8'hA5, 31'd100);      // equal wake time, behind 0x5A
        send_beat(OP_INSERT, 8'h3C, 31'd50);       // in front, shrinks follower delta
        send_beat(OP_INSERT, 8'h5A, 31'd200);      // same id held twice
        send_beat(OP_NOP, 8'h12, 31'd5);
        send_beat(OP_REMOVE, 8'h5A, '0);           // copy nearest the head goes
        send_beat(OP_REMOVE, 8'h77, '0);           // id not held
        send_beat(OP_REMOVE, 8'hFF, '0);           // tail with no successor
        send_beat(OP_REMOVE, 8'h00, '0);           // head with a successor
        send_beat(OP_POLL, 8'h00, '0);
        while (sleeper_count > 0)
            send_beat(OP_POLL, ID_W'($urandom_range(255)), DELTA_W'($urandom()));
        send_beat(OP_POLL, 8'h00, '0);             // back to empty
    endtask

    // Fill to capacity with random content, overflow it, remove one and insert twice, then poll it dry
    task automatic test_full_list();
        while (sleeper_count < ENTRIES)
            send_beat(OP_INSERT, pick_id(), pick_delay());
        send_beat(OP_INSERT, 8'hFF, '0);
        send_beat(OP_INSERT, 8'h00, DELAY_MAX);
        send_beat(OP_REMOVE, sleeper_ids[ENTRIES / 2], '0);
        send_beat(OP_INSERT, pick_id(), pick_delay());
        send_beat(OP_INSERT, pick_id(), pick_delay());
        while (sleeper_count > 0)
            send_beat(OP_POLL, ID_W'($urandom_range(255)), DELTA_W'($urandom()));
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls
    task automatic test_output_hold();
        int k;
        drain_results();
        rx_hold_left = HOLD_CYCLES;
        for (k = 0; k < 12; k++)
        begin
            if (k % 3 == 2)
                send_beat(OP_POLL, pick_id(), pick_delay());
            else
                send_beat(OP_INSERT, pick_id(), pick_delay());
        end
        // pause the sender until every beat has come back
        drain_results();
    endtask

    // Random mix steered toward a moving fill target so the list sweeps empty to full
    task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
        int              k;
        int              target;
        int              roll;
        int              insert_pct;
        logic [1:0]      op;
        logic [ID_W-1:0] pid;
        drain_results();
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        target       = ENTRIES / 2;
        for (k = 0; k < n_items; k++)
        begin
            if (k % 40 == 0)
            begin
                case ($urandom_range(3))
                    0:       target = 0;
                    1:       target = ENTRIES;
                    default: target = $urandom_range(ENTRIES);
                endcase
            end
            insert_pct = (sleeper_count < target) ? 70 : 30;
            roll       = $urandom_range(99);
            pid        = pick_id();
            if (roll < 3)
                op = OP_NOP;
            else if (roll < insert_pct)
                op = OP_INSERT;
            else if ($urandom_range(1) == 0)
                op = OP_POLL;
            else
            begin
                op = OP_REMOVE;
                // mostly aim at an id that is held, somewhere in the list
                if (sleeper_count > 0 && $urandom_range(4) != 0)
                    pid = sleeper_ids[$urandom_range(sleeper_count - 1)];
            end
            send_beat(op, pid, pick_delay());
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Drive ready on the falling edge; a forced hold-off overrides random stalls
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready    <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_stall_pct == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Compare every accepted output beat against the oldest owed result
    always @(posedge clk)
    begin
        sleep_result_t got;
        sleep_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            got = '{status, out_id, out_time, head_valid, head_id, head_delta, entry_count};
            if (results_due.size() == 0)
            begin
                report_mismatch("unexpected beat", 64'(1), 64'(0));
            end
            else
            begin
                want = results_due.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.out_id !== want.out_id)
                    report_mismatch("out_id", 64'(got.out_id), 64'(want.out_id));
                if (got.out_time !== want.out_time)
                    report_mismatch("out_time", 64'(got.out_time), 64'(want.out_time));
                if (got.head_valid !== want.head_valid)
                    report_mismatch("head_valid", 64'(got.head_valid),
                                    64'(want.head_valid));
                if (got.head_id !== want.head_id)
                    report_mismatch("head_id", 64'(got.head_id), 64'(want.head_id));
                if (got.head_delta !== want.head_delta)
                    report_mismatch("head_delta", 64'(got.head_delta),
                                    64'(want.head_delta));
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(got.entry_count),
                                    64'(want.entry_count));
            end
        end
    end

    // End the run if neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_ordering();
        test_full_list();
        test_output_hold();

        // idling phases: none, sender idle, receiver stalling, both
        test_random(180, 0, 0);
        test_random(180, 69, 0);
        test_random(180, 0, 69);
        test_random(180, 14, 14);

        drain_results();
        repeat (ENTRIES + 8) @(negedge clk);

        if (results_due.size() != 0)
            report_mismatch("missing beats", 64'(results_due.size()), 64'(0));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
